FILE: hdl/dpet_pkg.sv
package dpet_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned TIME_BITS = 24;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned SCALE_SH  = 8;
  localparam int unsigned WIDE_W    = 33;

  localparam logic [WIDE_W-1:0] TMAX_WIDE = (WIDE_W'(1) << TIME_BITS) - WIDE_W'(1);
  localparam logic [15:0]       SCALE_RESET = 16'd256;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD_ONE = 2'd1,
    CMD_ADD_REP = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_FIRED = 2'd0,
    RES_ADDED = 2'd1,
    RES_FULL  = 2'd2,
    RES_DONE  = 2'd3
  } res_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SAT  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] elapsed;
    logic [23:0] start_delay;
    logic [23:0] period;
    logic [7:0]  callback_id;
  } ev_in_t;

  typedef struct packed {
    res_e        event_res;
    logic [3:0]  slot;
    logic [7:0]  fired_id;
    logic [23:0] scaled_delta;
    logic        last;
  } ev_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 started;
    logic                 repeats;
    logic [TIME_BITS-1:0] wait_cnt;
    logic [TIME_BITS-1:0] first_delay;
    logic [TIME_BITS-1:0] repeat_period;
    logic [7:0]           callback;
  } slot_t;

  typedef struct packed {
    logic tick;
    logic alloc_en;
  } proc_ctl_t;

  typedef struct packed {
    logic fire;
    logic alloc;
  } proc_stat_t;

endpackage

FILE: hdl/delayed_and_periodic_event_timer_core.sv
// timer table with slot-numbered one-shot and repeating timers
// command channel: an item transfers on a clock edge with start high and busy low
// tick: 16 x 16 scale multiply, saturate, then one pass over all slots
// add: one pass over all slots, the lowest free slot takes the new timer
// the slots sit in a ring of cells that rotates one place per cycle during a pass,
// and a pass leaves every slot back in its own cell
// an unknown command is taken and dropped, busy stays low
// the next command can transfer at the edge that takes the final result, and no
// command is taken before that
// results: res_strobe_o marks one result for one cycle, firings in slot order
// during the pass, then tick done, added or table full with last set
// the receiver cannot stall, every strobed result is final
// time_scale write channel: a transfer on cfg_valid_i with cfg_ready_o, held
// ready; write only while the block is idle
// reset: all slots free, time_scale back to 1.0, no result pending
module delayed_and_periodic_event_timer_core
  import dpet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ev_in_t      cmd_i,
  output logic        res_strobe_o,
  output ev_out_t     res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  state_e               state_q, state_d;
  ev_in_t               cmd_q;
  logic [SLOT_W-1:0]    step_q, step_d;
  logic                 alloc_q, alloc_d;
  logic [SLOT_W-1:0]    alloc_slot_q, alloc_slot_d;
  logic [PROD_W-1:0]    prod_q;
  logic [TIME_BITS-1:0] scaled_q;
  logic [15:0]          scale_q;
  logic                 res_strobe_q, res_strobe_d;
  ev_out_t              res_q, res_d;

  slot_t                chain [SLOTS];
  slot_t                proc_next;
  slot_t                new_slot;
  proc_ctl_t            ctl;
  proc_stat_t           stat;
  logic                 shift;
  logic                 accept;
  logic                 last_step;
  logic [WIDE_W-1:0]    raw_wide;
  logic [TIME_BITS-1:0] scaled_d;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign shift       = (state_q == S_SCAN);
  assign last_step   = (step_q == SLOT_W'(SLOTS - 1));

  // slot ring
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      dpet_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .slot_i (proc_next),
        .slot_o (chain[i])
      );
    end else begin : g_body
      dpet_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .slot_i (chain[i+1]),
        .slot_o (chain[i])
      );
    end
  end

  assign new_slot = '{valid:         1'b1,
                      started:       1'b0,
                      repeats:       (cmd_q.command == CMD_ADD_REP),
                      wait_cnt:      '0,
                      first_delay:   TIME_BITS'(cmd_q.start_delay),
                      repeat_period: (cmd_q.command == CMD_ADD_REP) ?
                                     TIME_BITS'(cmd_q.period) : '0,
                      callback:      cmd_q.callback_id};

  assign ctl.tick     = (cmd_q.command == CMD_TICK);
  assign ctl.alloc_en = (cmd_q.command != CMD_TICK) && !alloc_q;

  dpet_slot_proc u_proc (
    .head_i    (chain[0]),
    .new_slot_i(new_slot),
    .ctl_i     (ctl),
    .scaled_i  (scaled_q),
    .next_o    (proc_next),
    .stat_o    (stat)
  );

  assign raw_wide = WIDE_W'(prod_q[PROD_W-1:SCALE_SH]);
  assign scaled_d = (raw_wide > TMAX_WIDE) ? '1 : TIME_BITS'(raw_wide);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    alloc_d      = alloc_q;
    alloc_slot_d = alloc_slot_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    unique case (state_q)
      S_IDLE: begin
        step_d  = '0;
        alloc_d = 1'b0;
        if (accept) begin
          unique case (cmd_i.command) inside
            CMD_TICK:                 state_d = S_MUL;
            CMD_ADD_ONE, CMD_ADD_REP: state_d = S_SCAN;
            default:                  state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        step_d = step_q + SLOT_W'(1);
        if (stat.alloc) begin
          alloc_d      = 1'b1;
          alloc_slot_d = step_q;
        end
        if (stat.fire) begin
          res_strobe_d = 1'b1;
          res_d        = '{event_res:    RES_FIRED,
                           slot:         4'(step_q),
                           fired_id:     chain[0].callback,
                           scaled_delta: '0,
                           last:         1'b0};
        end
        if (last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_strobe_d = 1'b1;
        state_d      = S_IDLE;
        if (cmd_q.command == CMD_TICK) begin
          res_d = '{event_res:    RES_DONE,
                    slot:         '0,
                    fired_id:     '0,
                    scaled_delta: 24'(scaled_q),
                    last:         1'b1};
        end else if (alloc_q) begin
          res_d = '{event_res:    RES_ADDED,
                    slot:         4'(alloc_slot_q),
                    fired_id:     '0,
                    scaled_delta: '0,
                    last:         1'b1};
        end else begin
          res_d = '{event_res:    RES_FULL,
                    slot:         '0,
                    fired_id:     '0,
                    scaled_delta: '0,
                    last:         1'b1};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      alloc_q      <= 1'b0;
      res_strobe_q <= 1'b0;
      scale_q      <= SCALE_RESET;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      alloc_q      <= alloc_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_slot_q <= alloc_slot_d;
    res_q        <= res_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(cmd_q.elapsed) * PROD_W'(scale_q);
    end
    if (state_q == S_SAT) begin
      scaled_q <= scaled_d;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

FILE: hdl/dpet_cell.sv
module dpet_cell
  import dpet_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic                 valid_q;
  logic                 started_q;
  logic                 repeats_q;
  logic [TIME_BITS-1:0] wait_q;
  logic [TIME_BITS-1:0] first_q;
  logic [TIME_BITS-1:0] period_q;
  logic [7:0]           callback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      started_q <= 1'b0;
    end else if (shift_i) begin
      valid_q   <= slot_i.valid;
      started_q <= slot_i.started;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      repeats_q  <= slot_i.repeats;
      wait_q     <= slot_i.wait_cnt;
      first_q    <= slot_i.first_delay;
      period_q   <= slot_i.repeat_period;
      callback_q <= slot_i.callback;
    end
  end

  assign slot_o = '{valid:         valid_q,
                    started:       started_q,
                    repeats:       repeats_q,
                    wait_cnt:      wait_q,
                    first_delay:   first_q,
                    repeat_period: period_q,
                    callback:      callback_q};

endmodule

FILE: hdl/dpet_slot_proc.sv
module dpet_slot_proc
  import dpet_pkg::*;
(
  input  slot_t                head_i,
  input  slot_t                new_slot_i,
  input  proc_ctl_t            ctl_i,
  input  logic [TIME_BITS-1:0] scaled_i,
  output slot_t                next_o,
  output proc_stat_t           stat_o
);

  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] w;
  logic [TIME_BITS-1:0] goal;

  assign sum  = {1'b0, head_i.wait_cnt} + {1'b0, scaled_i};
  assign w    = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign goal = head_i.started ? head_i.repeat_period : head_i.first_delay;

  always_comb begin
    next_o       = head_i;
    stat_o.fire  = 1'b0;
    stat_o.alloc = 1'b0;
    if (ctl_i.tick && head_i.valid) begin
      next_o.wait_cnt = w;
      if (w >= goal) begin
        stat_o.fire     = 1'b1;
        next_o.started  = 1'b1;
        next_o.wait_cnt = '0;
        if (!head_i.repeats) begin
          next_o.valid = 1'b0;
        end
      end
    end else if (ctl_i.alloc_en && !head_i.valid) begin
      next_o       = new_slot_i;
      stat_o.alloc = 1'b1;
    end
  end

endmodule

FILE: hdl/dpet_checker.sv
module dpet_checker
  import dpet_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input ev_in_t      cmd_i,
  input logic        res_strobe_o,
  input ev_out_t     res_o
);

  // only the closing result carries last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ((res_o.event_res == RES_FIRED) != res_o.last))
    else $error("last flag does not match result kind");

  // a firing only shows up while the pass is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |-> busy)
    else $error("firing reported outside a tick");

  // an add transfer keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.command == CMD_ADD_ONE || cmd_i.command == CMD_ADD_REP))
    |=> busy)
    else $error("add command not taken up");

  // a table full result names no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.event_res == RES_FULL) |-> (res_o.slot == '0))
    else $error("table full result with a slot number");

endmodule

bind delayed_and_periodic_event_timer_core dpet_checker u_dpet_checker (.*);

FILE: tb/tb_delayed_and_periodic_event_timer_core.sv
`timescale 1ns / 100ps

module tb_delayed_and_periodic_event_timer_core;
  import dpet_pkg::*;

  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 66;
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam int unsigned SETTLE_CYCLES = SLOTS + 6;

  typedef struct {
    ev_in_t  item;
    bit      typed;
    ev_out_t res;
  } stim_row_t;

  typedef struct {
    bit      typed;
    ev_out_t res;
  } row_note_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ev_in_t      cmd_i = '0;
  logic        res_strobe_o;
  ev_out_t     res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  ev_out_t     expected_events[$];
  row_note_t   row_notes[$];
  row_note_t   note_now;
  ev_out_t     event_now;
  int unsigned error_count = 0;
  bit          gaps_on = 1'b1;

  // timer table as predicted
  logic [15:0]          tmr_scale;
  bit                   tmr_valid   [SLOTS];
  bit                   tmr_started [SLOTS];
  bit                   tmr_repeats [SLOTS];
  logic [TIME_BITS-1:0] tmr_wait    [SLOTS];
  logic [TIME_BITS-1:0] tmr_first   [SLOTS];
  logic [TIME_BITS-1:0] tmr_period  [SLOTS];
  logic [7:0]           tmr_cb      [SLOTS];

  delayed_and_periodic_event_timer_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void clear_table();
    tmr_scale = SCALE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tmr_valid[i]   = 1'b0;
      tmr_started[i] = 1'b0;
      tmr_repeats[i] = 1'b0;
      tmr_wait[i]    = '0;
      tmr_first[i]   = '0;
      tmr_period[i]  = '0;
      tmr_cb[i]      = '0;
    end
  endfunction

  function automatic void queue_event(input ev_out_t r);
    expected_events = {expected_events, r};
  endfunction

  function automatic void predict_events(input ev_in_t it);
    logic [63:0] scaled;
    logic [63:0] sum;
    logic [63:0] goal;
    ev_out_t     r;
    bit          placed;
    placed = 1'b0;
    case (it.command)
      CMD_TICK: begin
        scaled = (64'(it.elapsed) * 64'(tmr_scale)) >> SCALE_SH;
        if (scaled > TIME_MAX) scaled = TIME_MAX;
        for (int i = 0; i < SLOTS; i++) begin
          if (tmr_valid[i]) begin
            sum = 64'(tmr_wait[i]) + scaled;
            if (sum > TIME_MAX) sum = TIME_MAX;
            tmr_wait[i] = sum[TIME_BITS-1:0];
            goal = tmr_started[i] ? 64'(tmr_period[i]) : 64'(tmr_first[i]);
            if (sum >= goal) begin
              r = '0;
              r.event_res = RES_FIRED;
              r.slot = 4'(i);
              r.fired_id = tmr_cb[i];
              queue_event(r);
              tmr_started[i] = 1'b1;
              tmr_wait[i] = '0;
              if (!tmr_repeats[i]) tmr_valid[i] = 1'b0;
            end
          end
        end
        r = '0;
        r.event_res = RES_DONE;
        r.scaled_delta = scaled[23:0];
        r.last = 1'b1;
        queue_event(r);
      end
      CMD_ADD_ONE, CMD_ADD_REP: begin
        r = '0;
        r.last = 1'b1;
        r.event_res = RES_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !tmr_valid[i]) begin
            placed = 1'b1;
            tmr_valid[i]   = 1'b1;
            tmr_started[i] = 1'b0;
            tmr_repeats[i] = (it.command == CMD_ADD_REP);
            tmr_wait[i]    = '0;
            tmr_first[i]   = it.start_delay[TIME_BITS-1:0];
            tmr_period[i]  = (it.command == CMD_ADD_REP) ? it.period[TIME_BITS-1:0] : '0;
            tmr_cb[i]      = it.callback_id;
            r.event_res = RES_ADDED;
            r.slot = 4'(i);
          end
        end
        queue_event(r);
      end
      default: ;
    endcase
  endfunction

  // prediction on each command transfer, checking on each result strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_events(cmd_i);
        if (row_notes.size() != 0) begin
          note_now = row_notes.pop_front();
          if (note_now.typed) begin
            void'(expected_events.pop_back());
            queue_event(note_now.res);
          end
        end
      end
      if (res_strobe_o) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          event_now = expected_events.pop_front();
          if (res_o.event_res !== event_now.event_res)
            report_mismatch($sformatf("event_res got %0d want %0d",
                                      res_o.event_res, event_now.event_res));
          if (res_o.slot !== event_now.slot)
            report_mismatch($sformatf("slot got %0d want %0d", res_o.slot, event_now.slot));
          if (res_o.fired_id !== event_now.fired_id)
            report_mismatch($sformatf("fired_id got %0h want %0h",
                                      res_o.fired_id, event_now.fired_id));
          if (res_o.scaled_delta !== event_now.scaled_delta)
            report_mismatch($sformatf("scaled_delta got %0h want %0h",
                                      res_o.scaled_delta, event_now.scaled_delta));
          if (res_o.last !== event_now.last)
            report_mismatch($sformatf("last got %0b want %0b", res_o.last, event_now.last));
        end
      end
    end
  end

  task automatic send_item(input ev_in_t it, input bit typed, input ev_out_t res);
    row_note_t n;
    n.typed = typed;
    n.res = res;
    row_notes = {row_notes, n};
    start <= 1'b1;
    cmd_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 99) < 15) idle_for($urandom_range(1, 24));
  endtask

  task automatic drain_results();
    idle_for(1);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tmr_scale = value;
  endtask

  function automatic logic [15:0] rand_elapsed();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'h0000;
    if (pick < 16) return 16'hFFFF;
    if (pick < 36) return 16'($urandom());
    return 16'($urandom_range(0, 4095));
  endfunction

  function automatic logic [23:0] rand_delay();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = ((4096 * int'(tmr_scale)) >> SCALE_SH) * 3 + 1;
    if (pick < 8) return 24'h000000;
    if (pick < 14) return 24'hFFFFFF;
    if (pick < 30) return 24'($urandom());
    return 24'($urandom_range(0, span));
  endfunction

  function automatic ev_in_t random_item();
    ev_in_t      it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.elapsed = rand_elapsed();
    it.start_delay = rand_delay();
    it.period = rand_delay();
    it.callback_id = 8'($urandom());
    if (pick < 55) it.command = CMD_TICK;
    else if (pick < 93) it.command = CMD_ADD_ONE;
    else if (pick < 97) it.command = CMD_ADD_REP;
    else it.command = CMD_NONE;
    return it;
  endfunction

  function automatic stim_row_t make_row(input cmd_e c, input logic [15:0] el,
                                         input logic [23:0] sd, input logic [23:0] per,
                                         input logic [7:0] cb, input bit typed,
                                         input res_e rc, input logic [3:0] sl,
                                         input logic [23:0] dl);
    stim_row_t row;
    row.item.command = c;
    row.item.elapsed = el;
    row.item.start_delay = sd;
    row.item.period = per;
    row.item.callback_id = cb;
    row.typed = typed;
    row.res = '0;
    row.res.event_res = rc;
    row.res.slot = sl;
    row.res.scaled_delta = dl;
    row.res.last = 1'b1;
    return row;
  endfunction

  initial begin
    stim_row_t   directed_rows[DIRECTED_ROWS];
    logic [15:0] phase_scales[PHASES];
    ev_in_t      it;
    int unsigned counted;

    clear_table();
    directed_rows[0] = make_row(CMD_TICK, 16'h0000, 24'h0, 24'h0, 8'h00,
                                1'b1, RES_DONE, 4'd0, 24'h0);
    directed_rows[1] = make_row(CMD_TICK, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF,
                                1'b1, RES_DONE, 4'd0, 24'h00FFFF);
    directed_rows[2] = make_row(CMD_ADD_ONE, 16'h0, 24'h0, 24'hFFFFFF, 8'hFF,
                                1'b1, RES_ADDED, 4'd0, 24'h0);
    directed_rows[3] = make_row(CMD_NONE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF,
                                1'b0, RES_FIRED, 4'd0, 24'h0);
    directed_rows[4] = make_row(CMD_TICK, 16'h0000, 24'h0, 24'h0, 8'h00,
                                1'b0, RES_FIRED, 4'd0, 24'h0);
    directed_rows[5] = make_row(CMD_ADD_REP, 16'hFFFF, 24'h000000, 24'hFFFFFF, 8'hA5,
                                1'b1, RES_ADDED, 4'd0, 24'h0);
    directed_rows[6] = make_row(CMD_ADD_ONE, 16'h1234, 24'hFFFFFF, 24'h0, 8'h00,
                                1'b1, RES_ADDED, 4'd1, 24'h0);
    directed_rows[7] = make_row(CMD_TICK, 16'hFFFF, 24'h0, 24'h0, 8'h00,
                                1'b0, RES_FIRED, 4'd0, 24'h0);
    // fill the rest of the table with short one-shots
    for (int k = 8; k < 22; k++)
      directed_rows[k] = make_row(CMD_ADD_ONE, 16'(k), 24'(k * 4000), 24'h5A5A5A,
                                  8'(8'h10 + k), 1'b0, RES_ADDED, 4'd0, 24'h0);
    directed_rows[22] = make_row(CMD_ADD_REP, 16'h0, 24'h1, 24'h1, 8'h77,
                                 1'b1, RES_FULL, 4'd0, 24'h0);
    directed_rows[23] = make_row(CMD_TICK, 16'hFFFF, 24'h0, 24'h0, 8'h00,
                                 1'b0, RES_FIRED, 4'd0, 24'h0);

    phase_scales[0] = SCALE_RESET;
    phase_scales[1] = 16'hFFFF;
    phase_scales[2] = 16'h0000;
    phase_scales[3] = 16'h0001;
    phase_scales[4] = 16'($urandom());
    phase_scales[5] = 16'h0180;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
      maybe_idle();
    end

    for (int p = 0; p < PHASES; p++) begin
      write_scale(phase_scales[p]);
      // a long stretch of random items, with no idle gaps in phases 2 and 3
      gaps_on = !(p == 2 || p == 3);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        if (it.command != CMD_NONE) counted++;
        if (p == 4 && counted == PHASE_ITEMS / 2) drain_results();
        else maybe_idle();
      end
    end

    drain_results();
    if (expected_events.size() != 0) report_mismatch("results still expected at the end");
    if (error_count == 0) begin
      $display("[delayed_and_periodic_event_timer_core] OK");
    end else begin
      $display("[delayed_and_periodic_event_timer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[delayed_and_periodic_event_timer_core] ERROR");
    $finish;
  end

endmodule

FILE: delayed_and_periodic_event_timer_core.f
hdl/dpet_pkg.sv
hdl/dpet_cell.sv
hdl/dpet_slot_proc.sv
hdl/delayed_and_periodic_event_timer_core.sv
hdl/dpet_checker.sv
tb/tb_delayed_and_periodic_event_timer_core.sv
